// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumWord = 8;
    localparam int unsigned BlkWord = 16;
    localparam int unsigned Rounds  = 64;

    typedef logic [WordW-1:0] t_word;

    // commands from controller to datapath
    typedef struct packed {
        logic load_byte;    // shift data byte into block words
        logic load_pad;     // shift 0x80 byte
        logic load_zero;    // shift zero byte
        logic load_len;     // shift next length byte
        logic start;        // copy chaining value into working vars
        logic round;        // run one round
        logic finish;       // add working vars into chaining value
        logic rearm;        // restore initial value and counters
        logic shift_out;    // rotate chaining value for digest readout
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;   // bytes in block
        logic       len_full; // next byte would overflow length
        logic       ovf;
        logic       last_round;
    } t_dp_sts;

    localparam t_word InitH [NumWord] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [Rounds] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== src/sha256_if.sv =====
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// valid/ready channels for message items and digest words
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_overflow;
    modport source (output valid, digest_word, word_index, last_word, length_overflow,
                    input ready);
    modport sink   (input valid, digest_word, word_index, last_word, length_overflow,
                    output ready);
endinterface

// ===== src/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// byte-serial sha-256: buffers a block, compresses it, pads, emits the digest
// ----------------------------------------------------------------------------
// channel | dir | payload                                          | item
// in_ch   | in  | data_byte, byte_present, end_of_message          | one byte step
// out_ch  | out | digest_word, word_index, last_word, length_overflow | one digest word
//
// one byte item per cycle while a block fills; the 64th byte starts the
// compression (load, 64 rounds on the single round unit, chaining add)
// end of message: padding to 56 bytes, 8 length bytes, one or two blocks,
// each compressed as above, then 8 digest words at the output
// reset: synchronous active low, restores the initial hash value and length
// the output stalls hold the digest word; input is not taken meanwhile
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha256_in_if.sink   in_ch,
    sha256_out_if.source out_ch
);
    sha256_pkg::t_dp_cmd cmd;
    sha256_pkg::t_dp_sts sts;
    sha256_pkg::t_word   h0;
    logic [2:0]          idx;

    // sequencer
    sha256_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_valid (out_ch.valid),
        .i_ready (out_ch.ready),
        .o_idx   (idx)
    );

    // compression datapath
    sha256_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (in_ch.data_byte),
        .o_sts   (sts),
        .o_h0    (h0)
    );

    // digest words rotate out of the chaining value, h0 first
    assign out_ch.digest_word     = h0;
    assign out_ch.word_index      = idx;
    assign out_ch.last_word       = &idx;
    assign out_ch.length_overflow = sts.ovf;

endmodule

// ===== src/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// sha256_dp
// block words, message schedule, working vars, chaining value and length
// ----------------------------------------------------------------------------
module sha256_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_dp_cmd   i_cmd,
    input  logic [7:0]            i_byte,
    output sha256_pkg::t_dp_sts   o_sts,
    output sha256_pkg::t_word     o_h0
);
    // block buffer as 16 words, shifted in bytewise; doubles as schedule window
    sha256_pkg::t_word r_w [sha256_pkg::BlkWord];
    sha256_pkg::t_word r_v [sha256_pkg::NumWord];
    sha256_pkg::t_word r_h [sha256_pkg::NumWord];
    logic [63:0]       r_len;
    logic [2:0]        r_len_idx;
    logic [5:0]        r_fill;
    logic [5:0]        r_rnd;
    logic              r_ovf;

    logic              shift_en;
    logic [7:0]        shift_byte;
    sha256_pkg::t_word n_wt;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;

    always_comb begin
        // a byte that would overflow the length is dropped, not shifted in
        shift_en   = (i_cmd.load_byte & ~(&r_len[63:3])) | i_cmd.load_pad
                   | i_cmd.load_zero | i_cmd.load_len;
        shift_byte = 8'd0;
        if (i_cmd.load_byte) begin
            shift_byte = i_byte;
        end else if (i_cmd.load_pad) begin
            shift_byte = sha256_pkg::PadByte;
        end else if (i_cmd.load_len) begin
            shift_byte = r_len[63 - 8*r_len_idx -: 8];
        end
        // window holds w[t..t+15] at slots 0..15
        n_wt = sha256_pkg::ssig1(r_w[14]) + r_w[9] + sha256_pkg::ssig0(r_w[1]) + r_w[0];
        t1 = r_v[7] + sha256_pkg::bsig1(r_v[4])
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + sha256_pkg::RoundK[r_rnd] + r_w[0];
        t2 = sha256_pkg::bsig0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], shift_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_wt;
        end
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rearm) begin
            r_h       <= sha256_pkg::InitH;
            r_len     <= 64'd0;
            r_len_idx <= 3'd0;
            r_fill    <= 6'd0;
            r_rnd     <= 6'd0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.load_byte) begin
                if (&r_len[63:3]) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + 64'd8;
                end
            end
            if (i_cmd.load_len) begin
                r_len_idx <= r_len_idx + 3'd1;
            end
            if (shift_en && !(i_cmd.load_byte && (&r_len[63:3]))) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.round) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < sha256_pkg::NumWord; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_cmd.shift_out) begin
                for (int i = 0; i < sha256_pkg::NumWord - 1; i++) begin
                    r_h[i] <= r_h[i+1];
                end
                r_h[sha256_pkg::NumWord-1] <= r_h[0];
            end
        end
    end

    assign o_sts.fill       = r_fill;
    assign o_sts.len_full   = &r_len[63:3];
    assign o_sts.ovf        = r_ovf;
    assign o_sts.last_round = &r_rnd;
    assign o_h0             = r_h[0];

endmodule

// ===== src/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer for byte intake, padding, rounds and digest readout
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_in_if.sink           in_ch,
    input  sha256_pkg::t_dp_sts i_sts,
    output sha256_pkg::t_dp_cmd o_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_idx
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PAD   = 8'b00000010,
        S_FILL  = 8'b00000100,
        S_LEN   = 8'b00001000,
        S_START = 8'b00010000,
        S_ROUND = 8'b00100000,
        S_ADD   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_pend, n_pend;   // end of message seen, pad byte not yet in
    logic       r_fin, n_fin;     // pad byte is in
    logic       r_lenup, n_lenup; // length bytes are in, last block
    logic [2:0] r_idx, n_idx;

    logic       acc;
    logic       takes_byte;

    assign in_ch.ready = (r_state == S_IDLE);
    assign acc         = in_ch.valid && in_ch.ready;
    assign takes_byte  = acc && in_ch.byte_present && !i_sts.ovf;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_fin   = r_fin;
        n_lenup = r_lenup;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load_byte = takes_byte;
                    n_pend          = in_ch.end_of_message;
                    if (takes_byte && !i_sts.len_full && (&i_sts.fill)) begin
                        n_state = S_START;
                    end else if (in_ch.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.load_pad = 1'b1;
                n_pend         = 1'b0;
                n_fin          = 1'b1;
                if (&i_sts.fill) begin
                    n_state = S_START;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_sts.fill == sha256_pkg::LenStart) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.load_zero = 1'b1;
                    if (&i_sts.fill) begin
                        n_state = S_START;
                    end
                end
            end
            S_LEN: begin
                o_cmd.load_len = 1'b1;
                if (&i_sts.fill) begin
                    n_lenup = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.last_round) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.finish = 1'b1;
                if (r_lenup) begin
                    n_state = S_OUT;
                end else if (r_fin) begin
                    n_state = S_FILL;
                end else if (r_pend) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx           = r_idx + 3'd1;
                    if (&r_idx) begin
                        o_cmd.rearm = 1'b1;
                        n_pend      = 1'b0;
                        n_fin       = 1'b0;
                        n_lenup     = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_fin   <= 1'b0;
            r_lenup <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_fin   <= n_fin;
            r_lenup <= n_lenup;
            r_idx   <= n_idx;
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_idx   = r_idx;

endmodule

// ===== src/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_checker
// port-level checks of the hasher
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word
);
    // no input taken while a digest is out
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input ready during digest");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (last_word == (word_index == 3'd7))) else $error("last flag");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !last_word |=> out_valid
            && word_index == $past(word_index) + 3'd1) else $error("word order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_index)) else $error("stall");
endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.word_index),
    .last_word  (out_ch.last_word)
);
